[hdl/sird_pkg.sv]
package sird_pkg;

  localparam int MAX_BASE   = 16;
  localparam int MAX_DIGITS = 32;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Symbol byte at position idx of the sixteen-entry alphabet.
  function automatic logic [7:0] symbol_at(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] idx);
    logic [127:0] all;
    all = {hi, lo};
    return all[{idx, 3'b000} +: 8];
  endfunction

endpackage

[hdl/signed_integer_to_radix_digits.sv]
// Channel  | Direction | Payload
// s_       | in        | tdata[31:0] value (signed)
// m_       | out       | tdata[7:0] character, tlast last_char
// cfg_     | in        | cfg_index selects base_size, symbols_low, symbols_high
//
// A request is accepted, the alphabet is checked one symbol per cycle up to base_size symbols,
// each digit comes from the shared 4-bit-per-cycle divider, then one character is sent per
// cycle when the output is not stalled. The divider loop over the digits takes the longest;
// s_tready is high only when idle.
// rst is synchronous and clears the configuration, the state, quotient, digit_count and m_tvalid.
// A stalled m_tready holds the current character and pauses the emission.
module signed_integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast,   // last_char
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sird_pkg::*;

  state_t state, state_next;

  logic [4:0]  base_size;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;

  logic        neg;
  logic [31:0] quotient;
  logic [4:0]  rem;
  logic [2:0]  step_cnt;
  logic [3:0]  chk_idx;
  logic [5:0]  digit_count;
  logic [4:0]  emit_idx;
  logic [3:0]  digit_store [MAX_DIGITS];

  // Input value held for the duration of the alphabet check.
  logic [31:0] s_value_hold;

  logic        base_ok;
  logic        chk_bad;
  logic        chk_last;
  logic [7:0]  chk_sym;
  logic [31:0] q_step;
  logic [4:0]  r_step;
  logic        digit_done;
  logic        div_finish;
  logic        out_free;
  logic        out_load;
  logic [7:0]  out_char;
  logic        out_last;

  assign base_ok  = (base_size >= 5'd2) && (base_size <= 5'(MAX_BASE));
  assign out_free = !m_tvalid || m_tready;

  // Alphabet check: one symbol per cycle against every later symbol in use and against NUL, + and -.
  always_comb begin
    logic dup;
    dup     = 1'b0;
    chk_sym = symbol_at(symbols_low, symbols_high, chk_idx);
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((5'(j) > {1'b0, chk_idx}) && (5'(j) < base_size) &&
          (symbol_at(symbols_low, symbols_high, 4'(j)) == chk_sym)) begin
        dup = 1'b1;
      end
    end
    chk_bad  = dup || (chk_sym == CHAR_NUL) || (chk_sym == CHAR_PLUS) ||
               (chk_sym == CHAR_MINUS);
    chk_last = ({1'b0, chk_idx} == (base_size - 5'd1));
  end

  // Shared divider: four restoring steps per cycle on the narrow remainder.
  always_comb begin
    logic [4:0] t;
    q_step = quotient;
    r_step = rem;
    for (int k = 0; k < 4; k++) begin
      t = {r_step[3:0], q_step[31]};
      if (t >= base_size) begin
        r_step = t - base_size;
        q_step = {q_step[30:0], 1'b1};
      end else begin
        r_step = t;
        q_step = {q_step[30:0], 1'b0};
      end
    end
  end

  assign digit_done = (step_cnt == 3'd7);
  assign div_finish = digit_done && ((q_step == 32'd0) || (digit_count == 6'(MAX_DIGITS - 1)));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && base_ok) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk_bad) state_next = ST_IDLE;
        else if (chk_last) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_finish) state_next = neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (emit_idx == 5'd0)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    out_char = CHAR_MINUS;
    out_last = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SIGN: out_load = out_free;
      ST_EMIT: begin
        out_load = out_free;
        out_char = symbol_at(symbols_low, symbols_high, digit_store[emit_idx]);
        out_last = (emit_idx == 5'd0);
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_size    <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
      quotient     <= '0;
      digit_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_SIZE:    base_size    <= cfg_data[4:0];
          REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default:          base_size    <= base_size;
        endcase
      end

      case (state)
        ST_IDLE: begin
          chk_idx <= '0;
          if (s_tvalid) begin
            neg <= s_tdata[31];
          end
        end
        ST_CHECK: begin
          chk_idx <= chk_idx + 4'd1;
          if (!chk_bad && chk_last) begin
            // The magnitude of the most negative value still fits in 32 unsigned bits.
            quotient    <= neg ? (32'd0 - s_value_hold) : s_value_hold;
            digit_count <= '0;
            step_cnt    <= '0;
            rem         <= '0;
          end
        end
        ST_DIV: begin
          quotient <= q_step;
          step_cnt <= step_cnt + 3'd1;
          rem      <= digit_done ? 5'd0 : r_step;
          if (digit_done) begin
            digit_store[digit_count[4:0]] <= r_step[3:0];
            digit_count <= digit_count + 6'd1;
            emit_idx    <= digit_count[4:0];
          end
        end
        ST_EMIT: begin
          if (out_free) emit_idx <= emit_idx - 5'd1;
        end
        default: chk_idx <= chk_idx;
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) s_value_hold <= s_tdata;
    if (out_load) begin
      m_tdata <= out_char;
      m_tlast <= out_last;
    end
  end

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sird_pkg::*;

  // Cycles the block may still need after its last character: checking, division
  // over 32 digits at radix two and the emission itself.
  localparam int SETTLE_CYCLES = 320;

  typedef enum {
    PACE_NONE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BASE_SIZE;
  logic [63:0] cfg_data = '0;

  // Local copy of the configuration, as last written.
  logic [4:0]  radix_cfg = '0;
  logic [63:0] sym_low_cfg = '0;
  logic [63:0] sym_high_cfg = '0;

  text_char_t  pending_chars[$];
  pace_e       pace = PACE_NONE;
  int          errors = 0;
  int          values_sent = 0;
  int          chars_checked = 0;
  int          settings_used = 0;

  signed_integer_to_radix_digits dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit sender_pause();
    int pct;
    pct = (pace == PACE_SENDER) ? 86 : (pace == PACE_BOTH) ? 9 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit receiver_stall();
    int pct;
    pct = (pace == PACE_RECEIVER) ? 86 : (pace == PACE_BOTH) ? 9 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [3:0] idx);
    logic [127:0] both;
    both = {sym_high_cfg, sym_low_cfg};
    return both[int'(idx) * 8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    logic [7:0] s;
    if (radix_cfg < 2 || radix_cfg > MAX_BASE) return 1'b0;
    for (int i = 0; i < radix_cfg; i++) begin
      s = alphabet_char(i[3:0]);
      if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_cfg; j++)
        if (s == alphabet_char(j[3:0])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the characters for one number and queues them.
  function automatic void predict_text(input logic [31:0] value);
    logic [31:0] quo;
    logic [31:0] radix;
    logic [3:0]  digits[MAX_DIGITS];
    int          count;
    if (!alphabet_valid()) return;
    radix = {27'd0, radix_cfg};
    // Unsigned negation keeps the most negative value exact.
    quo = value[31] ? (~value + 32'd1) : value;
    count = 0;
    do begin
      digits[count] = 4'(quo % radix);
      quo = quo / radix;
      count++;
    end while (quo != 0 && count < MAX_DIGITS);
    if (value[31]) pending_chars.push_back('{character: CHAR_MINUS, last_char: 1'b0});
    for (int i = count - 1; i >= 0; i--)
      pending_chars.push_back('{character: alphabet_char(digits[i]), last_char: i == 0});
  endfunction

  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: character %h (last %b) with none expected", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (m_tdata !== want.character) begin
          $display("%0t: character expected %h, got %h", $time, want.character, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last_char) begin
          $display("%0t: last_char expected %b, got %b", $time, want.last_char, m_tlast);
          errors++;
        end
      end
    end
    m_tready <= !receiver_stall();
  end

  // Leaves tvalid high after the request so that a following one can go out
  // in the very next cycle; the caller lowers it through settle().
  task automatic send_value(input logic [31:0] value);
    while (sender_pause()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_text(value);
    values_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      REG_BASE_SIZE:    radix_cfg = data[4:0];
      REG_SYMBOLS_LOW:  sym_low_cfg = data;
      REG_SYMBOLS_HIGH: sym_high_cfg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_alphabet(input logic [4:0] radix, input logic [63:0] lo,
                              input logic [63:0] hi);
    settle();
    write_reg(REG_BASE_SIZE, {59'd0, radix});
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HIGH, hi);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    // Radix zero and an all-zero alphabet straight out of reset: no text at all.
    send_value(32'd5);
  endtask

  task automatic test_decimal();
    set_alphabet(5'd10, "76543210", {48'd0, "98"});
    send_value(32'd0);
    send_value(32'd7);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1_000_000_000);
  endtask

  task automatic test_binary_extremes();
    // Upper symbols are all ones but lie outside the radix, so they do not matter.
    set_alphabet(5'd2, {48'd0, "10"}, '1);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h5555_5555);
  endtask

  task automatic test_hex_full();
    set_alphabet(5'd16, "76543210", "FEDCBA98");
    send_value(32'hDEAD_BEEF);
    send_value(32'h1234_5678);
    send_value(32'h8000_0001);
  endtask

  task automatic test_bad_alphabets();
    set_alphabet(5'd1, "76543210", "FEDCBA98");
    send_value(-32'sd12345);
    set_alphabet(5'd17, "76543210", "FEDCBA98");
    send_value(-32'sd12345);
    set_alphabet(5'd31, "76543210", "FEDCBA98");
    send_value(32'd12345);
    set_alphabet(5'd16, "76543210", "+EDCBA98");
    send_value(32'd12345);
    set_alphabet(5'd10, "7654321-", {48'd0, "98"});
    send_value(32'd12345);
    set_alphabet(5'd10, "76543210", {48'd0, 8'h00, "8"});
    send_value(32'd12345);
    set_alphabet(5'd16, "76543210", "FEDC3A98");
    send_value(32'd12345);
    set_alphabet(5'd2, '1, '0);
    send_value(32'd12345);
  endtask

  task automatic random_alphabet(output logic [4:0] radix, output logic [63:0] lo,
                                 output logic [63:0] hi);
    logic [7:0] syms[16];
    bit         used[256];
    logic [7:0] b;
    int         pos;
    int         n;
    case ($urandom_range(4))
      0:       n = 2;
      1:       n = 16;
      default: n = $urandom_range(3, 15);
    endcase
    for (int i = 0; i < 16; i++) begin
      if (i < n) begin
        do b = 8'($urandom_range(1, 255));
        while (used[b] || b == CHAR_PLUS || b == CHAR_MINUS);
        used[b] = 1'b1;
        syms[i] = b;
      end else begin
        syms[i] = 8'($urandom_range(255));
      end
    end
    radix = 5'(n);
    // One setting in five is spoilt in some way.
    if ($urandom_range(4) == 0) begin
      pos = $urandom_range(n - 1);
      case ($urandom_range(4))
        0: syms[pos] = CHAR_PLUS;
        1: syms[pos] = CHAR_MINUS;
        2: syms[pos] = CHAR_NUL;
        3: syms[pos] = syms[(pos + $urandom_range(1, n - 1)) % n];
        default: radix = $urandom_range(1) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1));
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[i * 8 +: 8] = syms[i];
      hi[i * 8 +: 8] = syms[i + 8];
    end
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'($urandom_range(20));
      2: return ~32'($urandom_range(1, 20)) + 32'd1;
      3: begin
        case ($urandom_range(2))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random_conversions();
    logic [4:0]  radix;
    logic [63:0] lo;
    logic [63:0] hi;
    pace_e       modes[4];
    modes = '{PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH};
    foreach (modes[m]) begin
      settle();
      pace = modes[m];
      for (int c = 0; c < 4; c++) begin
        random_alphabet(radix, lo, hi);
        set_alphabet(radix, lo, hi);
        for (int k = 0; k < 8; k++) send_value(random_value());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_decimal();
    test_binary_extremes();
    test_hex_full();
    test_bad_alphabets();
    test_random_conversions();
    settle();
    $display("tb: %0d values converted under %0d alphabet settings, %0d characters checked",
             values_sent, settings_used, chars_checked);
    $display("tb: radix 0 to 31, spoilt alphabets, range extremes, four pacing modes");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: timed out with %0d characters outstanding", pending_chars.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule

[files.f]
hdl/sird_pkg.sv
hdl/signed_integer_to_radix_digits.sv
sim/tb.sv
